>>> design/lscr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line segment rectangle clipper.
// No dependencies; every other design file refers to this package by scoped names.
package lscr_pkg;

    localparam int COORD_BITS = 16;
    localparam int DEN_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int OFF_BITS   = 2 * COORD_BITS + 1;
    localparam int NUM_BITS   = 2 * COORD_BITS + 2;
    localparam int QUO_BITS   = NUM_BITS + 1;
    localparam int LANES      = 4;
    localparam int CFG_IDX_BITS = 2;

    // Division lanes: top and bottom divide by dy, left and right by dx.
    localparam int LN_TOP    = 0;
    localparam int LN_BOTTOM = 1;
    localparam int LN_LEFT   = 2;
    localparam int LN_RIGHT  = 3;

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        ST_REJECT       = 3'd0,
        ST_UNCHANGED    = 3'd1,
        ST_ONE_CLIPPED  = 3'd2,
        ST_BOTH_CLIPPED = 3'd3,
        ST_POINT        = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_BOTTOM = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_clip;

    // Endpoints after ordering, with their outcodes.
    typedef struct packed {
        t_coord     x1;
        t_coord     y1;
        t_coord     x2;
        t_coord     y2;
        logic [3:0] c1;
        logic [3:0] c2;
        logic       dx_zero;
        logic       dy_zero;
    } t_side;

    typedef struct packed {
        logic [LANES-1:0][NUM_BITS-1:0] num;
        logic [LANES-1:0][DEN_BITS-1:0] den;
        logic [LANES-1:0]               neg;
        t_side                          side;
    } t_div_in;

    typedef struct packed {
        logic [LANES-1:0][NUM_BITS-1:0] quo;
        logic [LANES-1:0]               neg;
        t_side                          side;
    } t_div_out;

endpackage

>>> design/lscr_seg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one line segment.
// Depends on lscr_pkg for the coordinate type.
interface lscr_seg_if;
    logic            valid;
    logic            ready;
    lscr_pkg::t_coord start_x;
    lscr_pkg::t_coord start_y;
    lscr_pkg::t_coord end_x;
    lscr_pkg::t_coord end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> design/lscr_res_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one clipping result.
// Depends on lscr_pkg for the coordinate type.
interface lscr_res_if;
    logic             valid;
    logic             ready;
    logic [2:0]       clip_status;
    lscr_pkg::t_coord out_start_x;
    lscr_pkg::t_coord out_start_y;
    lscr_pkg::t_coord out_end_x;
    lscr_pkg::t_coord out_end_y;

    modport source (output valid, clip_status, out_start_x, out_start_y, out_end_x, out_end_y,
                    input ready);
    modport sink   (input valid, clip_status, out_start_x, out_start_y, out_end_x, out_end_y,
                    output ready);
endinterface

>>> design/lscr_front.sv
`timescale 1ns / 1ps
// Front stages: input register, outcodes and ordering, products, numerators.
// Depends on lscr_pkg; feeds lscr_div.
module lscr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lscr_pkg::t_coord   i_x1,
    input  lscr_pkg::t_coord   i_y1,
    input  lscr_pkg::t_coord   i_x2,
    input  lscr_pkg::t_coord   i_y2,
    input  lscr_pkg::t_clip    i_clip,
    output logic               o_valid,
    output lscr_pkg::t_div_in  o_data
);
    function automatic logic [3:0] outcode(input lscr_pkg::t_coord x, input lscr_pkg::t_coord y,
                                           input lscr_pkg::t_clip c);
        logic [3:0] oc;
        oc = 4'd0;
        if (x < c.left)   oc = oc | lscr_pkg::OC_LEFT;
        if (x > c.right)  oc = oc | lscr_pkg::OC_RIGHT;
        if (y < c.top)    oc = oc | lscr_pkg::OC_TOP;
        if (y > c.bottom) oc = oc | lscr_pkg::OC_BOTTOM;
        return oc;
    endfunction

    // Stage 0: input register.
    logic             r0_v;
    lscr_pkg::t_coord r0_x1, r0_y1, r0_x2, r0_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
        if (i_en) begin
            r0_x1 <= i_x1;
            r0_y1 <= i_y1;
            r0_x2 <= i_x2;
            r0_y2 <= i_y2;
        end
    end

    // Stage 1: outcodes, ordering by outcode, deltas and cross products.
    logic [3:0]                         a_c1, a_c2;
    logic                               a_swap;
    lscr_pkg::t_side                    n1_side;
    logic signed [lscr_pkg::DEN_BITS-1:0]  n1_dx, n1_dy;
    logic signed [lscr_pkg::PROD_BITS-1:0] n1_p1, n1_p2;

    always_comb begin
        a_c1   = outcode(r0_x1, r0_y1, i_clip);
        a_c2   = outcode(r0_x2, r0_y2, i_clip);
        a_swap = a_c1 > a_c2;
        n1_side.x1 = a_swap ? r0_x2 : r0_x1;
        n1_side.y1 = a_swap ? r0_y2 : r0_y1;
        n1_side.x2 = a_swap ? r0_x1 : r0_x2;
        n1_side.y2 = a_swap ? r0_y1 : r0_y2;
        n1_side.c1 = a_swap ? a_c2 : a_c1;
        n1_side.c2 = a_swap ? a_c1 : a_c2;
        n1_dx = lscr_pkg::DEN_BITS'(n1_side.x2) - lscr_pkg::DEN_BITS'(n1_side.x1);
        n1_dy = lscr_pkg::DEN_BITS'(n1_side.y2) - lscr_pkg::DEN_BITS'(n1_side.y1);
        n1_side.dx_zero = n1_dx == '0;
        n1_side.dy_zero = n1_dy == '0;
        n1_p1 = lscr_pkg::PROD_BITS'(n1_side.x2) * lscr_pkg::PROD_BITS'(n1_side.y1);
        n1_p2 = lscr_pkg::PROD_BITS'(n1_side.y2) * lscr_pkg::PROD_BITS'(n1_side.x1);
    end

    logic                                  r1_v;
    lscr_pkg::t_side                       r1_side;
    logic signed [lscr_pkg::DEN_BITS-1:0]  r1_dx, r1_dy;
    logic signed [lscr_pkg::PROD_BITS-1:0] r1_p1, r1_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= r0_v;
        end
        if (i_en) begin
            r1_side <= n1_side;
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
            r1_p1   <= n1_p1;
            r1_p2   <= n1_p2;
        end
    end

    // Stage 2: line offset and the delta-times-bound products.
    logic signed [lscr_pkg::OFF_BITS-1:0] n2_off, n2_mt, n2_mb, n2_ml, n2_mr;

    always_comb begin
        n2_off = lscr_pkg::OFF_BITS'(r1_p1) - lscr_pkg::OFF_BITS'(r1_p2);
        n2_mt  = lscr_pkg::OFF_BITS'(r1_dx) * lscr_pkg::OFF_BITS'(i_clip.top);
        n2_mb  = lscr_pkg::OFF_BITS'(r1_dx) * lscr_pkg::OFF_BITS'(i_clip.bottom);
        n2_ml  = lscr_pkg::OFF_BITS'(r1_dy) * lscr_pkg::OFF_BITS'(i_clip.left);
        n2_mr  = lscr_pkg::OFF_BITS'(r1_dy) * lscr_pkg::OFF_BITS'(i_clip.right);
    end

    logic                                 r2_v;
    lscr_pkg::t_side                      r2_side;
    logic signed [lscr_pkg::DEN_BITS-1:0] r2_dx, r2_dy;
    logic signed [lscr_pkg::OFF_BITS-1:0] r2_off, r2_mt, r2_mb, r2_ml, r2_mr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_side <= r1_side;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_off  <= n2_off;
            r2_mt   <= n2_mt;
            r2_mb   <= n2_mb;
            r2_ml   <= n2_ml;
            r2_mr   <= n2_mr;
        end
    end

    // Stage 3: signed numerators split into magnitude and quotient sign.
    logic signed [lscr_pkg::NUM_BITS-1:0] c_num [lscr_pkg::LANES];
    logic signed [lscr_pkg::DEN_BITS-1:0] c_den [lscr_pkg::LANES];
    lscr_pkg::t_div_in                    n3_d;

    always_comb begin
        c_num[lscr_pkg::LN_TOP]    = lscr_pkg::NUM_BITS'(r2_mt) - lscr_pkg::NUM_BITS'(r2_off);
        c_num[lscr_pkg::LN_BOTTOM] = lscr_pkg::NUM_BITS'(r2_mb) - lscr_pkg::NUM_BITS'(r2_off);
        c_num[lscr_pkg::LN_LEFT]   = lscr_pkg::NUM_BITS'(r2_ml) + lscr_pkg::NUM_BITS'(r2_off);
        c_num[lscr_pkg::LN_RIGHT]  = lscr_pkg::NUM_BITS'(r2_mr) + lscr_pkg::NUM_BITS'(r2_off);
        c_den[lscr_pkg::LN_TOP]    = r2_dy;
        c_den[lscr_pkg::LN_BOTTOM] = r2_dy;
        c_den[lscr_pkg::LN_LEFT]   = r2_dx;
        c_den[lscr_pkg::LN_RIGHT]  = r2_dx;
        n3_d.side = r2_side;
        for (int l = 0; l < lscr_pkg::LANES; l++) begin
            n3_d.num[l] = c_num[l][lscr_pkg::NUM_BITS-1] ? -c_num[l] : c_num[l];
            n3_d.den[l] = c_den[l][lscr_pkg::DEN_BITS-1] ? -c_den[l] : c_den[l];
            n3_d.neg[l] = c_num[l][lscr_pkg::NUM_BITS-1] ^ c_den[l][lscr_pkg::DEN_BITS-1];
        end
    end

    logic              r3_v;
    lscr_pkg::t_div_in r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_d <= n3_d;
        end
    end

    assign o_valid = r3_v;
    assign o_data  = r3_d;
endmodule

>>> design/lscr_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, four unsigned lanes, one quotient bit per stage.
// Depends on lscr_pkg; sits between lscr_front and lscr_back.
module lscr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lscr_pkg::t_div_in  i_data,
    output logic               o_valid,
    output lscr_pkg::t_div_out o_data
);
    localparam int NB = lscr_pkg::NUM_BITS;
    localparam int DB = lscr_pkg::DEN_BITS;
    localparam int LN = lscr_pkg::LANES;

    // Each stage shifts the numerator out at the top and the quotient in at the bottom.
    logic                          r_v    [NB];
    logic [LN-1:0][DB-1:0]         r_rem  [NB];
    logic [LN-1:0][NB-1:0]         r_nq   [NB];
    logic [LN-1:0][DB-1:0]         r_den  [NB];
    logic [LN-1:0]                 r_neg  [NB];
    lscr_pkg::t_side               r_side [NB];

    logic [LN-1:0][DB-1:0]         n_rem  [NB];
    logic [LN-1:0][NB-1:0]         n_nq   [NB];

    always_comb begin
        logic [LN-1:0][DB-1:0] s_rem;
        logic [LN-1:0][NB-1:0] s_nq;
        logic [LN-1:0][DB-1:0] s_den;
        logic [DB-1:0]         sh;
        logic                  ge;
        for (int k = 0; k < NB; k++) begin
            if (k == 0) begin
                s_rem = '0;
                s_nq  = i_data.num;
                s_den = i_data.den;
            end else begin
                s_rem = r_rem[k-1];
                s_nq  = r_nq[k-1];
                s_den = r_den[k-1];
            end
            for (int l = 0; l < LN; l++) begin
                sh = {s_rem[l][DB-2:0], s_nq[l][NB-1]};
                ge = sh >= s_den[l];
                n_rem[k][l] = ge ? sh - s_den[l] : sh;
                n_nq[k][l]  = {s_nq[l][NB-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NB; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NB; k++) r_v[k] <= r_v[k-1];
        end
        if (i_en) begin
            r_den[0]  <= i_data.den;
            r_neg[0]  <= i_data.neg;
            r_side[0] <= i_data.side;
            for (int k = 1; k < NB; k++) begin
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NB; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
            end
        end
    end

    assign o_valid     = r_v[NB-1];
    assign o_data.quo  = r_nq[NB-1];
    assign o_data.neg  = r_neg[NB-1];
    assign o_data.side = r_side[NB-1];
endmodule

>>> design/lscr_back.sv
`timescale 1ns / 1ps
// Back stages: signed crossings, then case selection into the output register.
// Depends on lscr_pkg; takes the quotients from lscr_div.
module lscr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lscr_pkg::t_div_out i_data,
    input  lscr_pkg::t_clip    i_clip,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output lscr_pkg::t_coord   o_ax,
    output lscr_pkg::t_coord   o_ay,
    output lscr_pkg::t_coord   o_bx,
    output lscr_pkg::t_coord   o_by
);
    localparam int QB = lscr_pkg::QUO_BITS;
    localparam int CB = lscr_pkg::COORD_BITS;

    // Stage E: apply sign; a zero divisor gives zero for its pair.
    logic signed [QB-1:0] n_q [lscr_pkg::LANES];

    always_comb begin
        logic signed [QB-1:0] mag;
        logic                 zero;
        for (int l = 0; l < lscr_pkg::LANES; l++) begin
            mag  = signed'({1'b0, i_data.quo[l]});
            zero = (l == lscr_pkg::LN_TOP || l == lscr_pkg::LN_BOTTOM) ?
                   i_data.side.dy_zero : i_data.side.dx_zero;
            n_q[l] = zero ? '0 : (i_data.neg[l] ? -mag : mag);
        end
    end

    logic                 r_e_v;
    logic signed [QB-1:0] r_e_q [lscr_pkg::LANES];
    lscr_pkg::t_side      r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= i_valid;
        end
        if (i_en) begin
            r_e_q    <= n_q;
            r_e_side <= i_data.side;
        end
    end

    // Stage F: classify and pick the output points.
    logic signed [QB-1:0] xt, xb, yl, yr, cl, ct, cr, cbt;
    logic                 k_top, k_left, k_bot, k_right;
    logic signed [QB-1:0] ex, ey;
    logic signed [QB-1:0] cand_x [4];
    logic signed [QB-1:0] cand_y [4];
    logic [3:0]           keep;
    logic [1:0]           i0, i1;
    logic                 found0, found1;
    lscr_pkg::t_status    n_status;
    logic signed [QB-1:0] n_ax, n_ay, n_bx, n_by;

    always_comb begin
        xt  = r_e_q[lscr_pkg::LN_TOP];
        xb  = r_e_q[lscr_pkg::LN_BOTTOM];
        yl  = r_e_q[lscr_pkg::LN_LEFT];
        yr  = r_e_q[lscr_pkg::LN_RIGHT];
        cl  = QB'(i_clip.left);
        ct  = QB'(i_clip.top);
        cr  = QB'(i_clip.right);
        cbt = QB'(i_clip.bottom);

        // Outside endpoint with a corner code: the side crossing wins if it is in range.
        ex = QB'(r_e_side.x2);
        ey = QB'(r_e_side.y2);
        case (r_e_side.c2)
            lscr_pkg::OC_TOP:    begin ex = xt; ey = ct;  end
            lscr_pkg::OC_BOTTOM: begin ex = xb; ey = cbt; end
            lscr_pkg::OC_LEFT:   begin ex = cl; ey = yl;  end
            lscr_pkg::OC_RIGHT:  begin ex = cr; ey = yr;  end
            lscr_pkg::OC_TOP | lscr_pkg::OC_LEFT: begin
                if (yl >= ct && yl <= cbt) begin ex = cl; ey = yl; end
                else begin ex = xt; ey = ct; end
            end
            lscr_pkg::OC_BOTTOM | lscr_pkg::OC_LEFT: begin
                if (yl >= ct && yl <= cbt) begin ex = cl; ey = yl; end
                else begin ex = xb; ey = cbt; end
            end
            lscr_pkg::OC_TOP | lscr_pkg::OC_RIGHT: begin
                if (yr >= ct && yr <= cbt) begin ex = cr; ey = yr; end
                else begin ex = xt; ey = ct; end
            end
            lscr_pkg::OC_BOTTOM | lscr_pkg::OC_RIGHT: begin
                if (yr >= ct && yr <= cbt) begin ex = cr; ey = yr; end
                else begin ex = xb; ey = cbt; end
            end
            default: ;
        endcase

        k_top   = cl < xt && xt < cr;
        k_left  = yl >= ct && yl <= cbt;
        k_bot   = cl < xb && xb < cr;
        k_right = yr >= ct && yr <= cbt;
        keep = {k_right, k_bot, k_left, k_top};
        cand_x[0] = xt; cand_y[0] = ct;
        cand_x[1] = cl; cand_y[1] = yl;
        cand_x[2] = xb; cand_y[2] = cbt;
        cand_x[3] = cr; cand_y[3] = yr;

        // First and second kept crossing in collection order.
        found0 = 1'b0;
        found1 = 1'b0;
        i0 = 2'd0;
        i1 = 2'd0;
        for (int j = 0; j < 4; j++) begin
            if (keep[j] && found0 && !found1) begin
                found1 = 1'b1;
                i1 = 2'(j);
            end
            if (keep[j] && !found0) begin
                found0 = 1'b1;
                i0 = 2'(j);
            end
        end

        n_status = lscr_pkg::ST_REJECT;
        n_ax = '0; n_ay = '0; n_bx = '0; n_by = '0;
        if ((r_e_side.c1 & r_e_side.c2) != 4'd0) begin
            n_status = lscr_pkg::ST_REJECT;
        end else if (r_e_side.c1 == 4'd0 && r_e_side.c2 == 4'd0) begin
            n_status = lscr_pkg::ST_UNCHANGED;
            n_ax = QB'(r_e_side.x1); n_ay = QB'(r_e_side.y1);
            n_bx = QB'(r_e_side.x2); n_by = QB'(r_e_side.y2);
        end else if (r_e_side.c1 == 4'd0) begin
            n_status = lscr_pkg::ST_ONE_CLIPPED;
            n_ax = QB'(r_e_side.x1); n_ay = QB'(r_e_side.y1);
            n_bx = ex; n_by = ey;
        end else if (found1) begin
            n_status = lscr_pkg::ST_BOTH_CLIPPED;
            n_ax = cand_x[i0]; n_ay = cand_y[i0];
            n_bx = cand_x[i1]; n_by = cand_y[i1];
        end else if (found0) begin
            n_status = lscr_pkg::ST_POINT;
            n_ax = cand_x[i0]; n_ay = cand_y[i0];
            n_bx = cand_x[i0]; n_by = cand_y[i0];
        end
    end

    logic              r_f_v;
    lscr_pkg::t_status r_f_status;
    lscr_pkg::t_coord  r_f_ax, r_f_ay, r_f_bx, r_f_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_e_v;
        end
        if (i_en) begin
            r_f_status <= n_status;
            r_f_ax <= n_ax[CB-1:0];
            r_f_ay <= n_ay[CB-1:0];
            r_f_bx <= n_bx[CB-1:0];
            r_f_by <= n_by[CB-1:0];
        end
    end

    assign o_valid  = r_f_v;
    assign o_status = r_f_status;
    assign o_ax     = r_f_ax;
    assign o_ay     = r_f_ay;
    assign o_bx     = r_f_bx;
    assign o_by     = r_f_by;
endmodule

>>> design/line_segment_rect_clipper.sv
`timescale 1ns / 1ps
// Line segment clipper against a programmable inclusive rectangle.
// Segments enter on i_seg and clipped results leave on o_res; both are
// valid/ready channels, and a transaction completes when valid and ready
// are high at the same rising edge. Every segment gives exactly one result.
// The clip rectangle is written through i_cfg_we/i_cfg_idx/i_cfg_data
// (left, top, right, bottom) while no segment is in flight.
// Throughput is one segment per cycle unless a stalled result holds the
// pipeline. It has four front stages for outcodes, products and
// numerators, one restoring-divider stage per numerator bit, and two back
// stages for sign fixing and result selection.
// When o_res.valid is high and o_res.ready is low the whole pipeline holds in
// place and i_seg.ready drops in the same cycle, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the rectangle to
// left 0, top 0, right 32767, bottom 32767.
// Depends on lscr_pkg, lscr_seg_if, lscr_res_if, lscr_front, lscr_div, lscr_back.
module line_segment_rect_clipper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lscr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lscr_pkg::COORD_BITS-1:0]     i_cfg_data,
    lscr_seg_if.sink                            i_seg,
    lscr_res_if.source                          o_res
);
    lscr_pkg::t_clip r_clip;
    logic            en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.left   <= '0;
            r_clip.top    <= '0;
            r_clip.right  <= {1'b0, {(lscr_pkg::COORD_BITS-1){1'b1}}};
            r_clip.bottom <= {1'b0, {(lscr_pkg::COORD_BITS-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (lscr_pkg::t_cfg_idx'(i_cfg_idx))
                lscr_pkg::CFG_LEFT:   r_clip.left   <= i_cfg_data;
                lscr_pkg::CFG_TOP:    r_clip.top    <= i_cfg_data;
                lscr_pkg::CFG_RIGHT:  r_clip.right  <= i_cfg_data;
                lscr_pkg::CFG_BOTTOM: r_clip.bottom <= i_cfg_data;
            endcase
        end
    end

    logic               f_valid, d_valid;
    lscr_pkg::t_div_in  f_data;
    lscr_pkg::t_div_out d_data;

    assign en          = !o_res.valid || o_res.ready;
    assign i_seg.ready = en;

    lscr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_seg.valid),
        .i_x1    (i_seg.start_x),
        .i_y1    (i_seg.start_y),
        .i_x2    (i_seg.end_x),
        .i_y2    (i_seg.end_y),
        .i_clip  (r_clip),
        .o_valid (f_valid),
        .o_data  (f_data)
    );

    lscr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_data  (f_data),
        .o_valid (d_valid),
        .o_data  (d_data)
    );

    lscr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_valid),
        .i_data   (d_data),
        .i_clip   (r_clip),
        .o_valid  (o_res.valid),
        .o_status (o_res.clip_status),
        .o_ax     (o_res.out_start_x),
        .o_ay     (o_res.out_start_y),
        .o_bx     (o_res.out_end_x),
        .o_by     (o_res.out_end_y)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.clip_status == lscr_pkg::ST_REJECT |->
        o_res.out_start_x == '0 && o_res.out_start_y == '0 &&
        o_res.out_end_x == '0 && o_res.out_end_y == '0)
        else $error("rejected segment with nonzero coordinates");

    a_point_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.clip_status == lscr_pkg::ST_POINT |->
        o_res.out_start_x == o_res.out_end_x && o_res.out_start_y == o_res.out_end_y)
        else $error("single point result with differing ends");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.clip_status <= lscr_pkg::ST_POINT)
        else $error("status code out of range");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_seg.ready)
        else $error("input accepted while the pipeline is stalled");
endmodule
